>>> sv/bed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bed_pkg
// Types, codes and character helpers shared by the escape decoder modules.
// ----------------------------------------------------------------------------
package bed_pkg;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_HEX    = 2'd2,
    PH_OCTAL  = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic CFG_INTERPRET = 1'b0;
  localparam logic CFG_NEWLINE   = 1'b1;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_NUL       = 8'h00;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_in;
    logic       end_of_arg;
    logic       end_of_all;
  } item_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]      count;
    phase_t          phase_next;
    logic [7:0]      acc_next;
  } result_t;

  // {valid, byte} for the single-letter control escapes
  function automatic logic [8:0] control_byte(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h65:   r = {1'b1, 8'd27};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // {valid, nibble} for a hex digit of either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/bed_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bed_decode
// One-item decode: up to three output bytes and the next escape state.
// ----------------------------------------------------------------------------
module bed_decode
  import bed_pkg::*;
(
  input  var item_t      item,
  input  var phase_t     phase,
  input  wire [7:0]      acc,
  input  wire            interpret_escapes,
  input  wire            append_newline,
  output result_t        res
);

  logic [2:0][7:0] slot;
  logic [1:0]      cnt;
  phase_t          ph;
  logic [7:0]      ac;
  logic            arg_end;
  logic [8:0]      ctrl;
  logic [4:0]      hexd;
  logic [7:0]      c;

  always_comb begin
    slot    = '0;
    cnt     = 2'd0;
    ph      = phase;
    ac      = acc;
    c       = item.char_in;
    arg_end = item.end_of_arg | item.end_of_all;
    ctrl    = control_byte(c);
    hexd    = hex_digit(c);

    if (interpret_escapes) begin
      if (item.has_char) begin
        unique case (ph)
          PH_NORMAL: begin
            if (c == CH_BACKSLASH) begin
              ph = PH_ESCAPE;
            end else begin
              slot[cnt] = c;
              cnt = cnt + 2'd1;
            end
          end
          PH_ESCAPE: begin
            ph = PH_NORMAL;
            if (ctrl[8]) begin
              slot[cnt] = ctrl[7:0];
              cnt = cnt + 2'd1;
            end else if (c == CH_X) begin
              ph = PH_HEX;
              ac = 8'd0;
            end else if (c == CH_ZERO) begin
              ph = PH_OCTAL;
              ac = 8'd0;
            end else begin
              slot[cnt] = c;
              cnt = cnt + 2'd1;
            end
          end
          PH_HEX, PH_OCTAL: begin
            if (ph == PH_HEX && hexd[4]) begin
              ac = {ac[3:0], hexd[3:0]};
            end else if (ph == PH_OCTAL && c[7:3] == 5'b00110) begin
              ac = {ac[4:0], c[2:0]};
            end else begin
              // run ends: flush value, then treat the character as normal
              slot[cnt] = ac;
              cnt = cnt + 2'd1;
              if (c == CH_BACKSLASH) begin
                ph = PH_ESCAPE;
              end else begin
                ph = PH_NORMAL;
                slot[cnt] = c;
                cnt = cnt + 2'd1;
              end
            end
          end
          default: ph = PH_NORMAL;
        endcase
      end
      if (arg_end) begin
        if (ph == PH_ESCAPE) begin
          slot[cnt] = CH_NUL;
          cnt = cnt + 2'd1;
        end else if (ph == PH_HEX || ph == PH_OCTAL) begin
          slot[cnt] = ac;
          cnt = cnt + 2'd1;
        end
      end
    end else begin
      if (item.has_char) begin
        slot[cnt] = c;
        cnt = cnt + 2'd1;
      end
      if (arg_end) begin
        slot[cnt] = CH_SPACE;
        cnt = cnt + 2'd1;
      end
    end

    if (arg_end) begin
      ph = PH_NORMAL;
      ac = 8'd0;
    end

    if (item.end_of_all && append_newline) begin
      slot[cnt] = CH_NEWLINE;
      cnt = cnt + 2'd1;
    end

    res.bytes      = slot;
    res.count      = cnt;
    res.phase_next = ph;
    res.acc_next   = ac;
  end

endmodule
`default_nettype wire

>>> sv/backslash_escape_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top
// Backslash-escape decoder for argument text, one character per transfer.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry has_char, char_in, end_of_arg and
// end_of_all. Output channel: out_valid / out_stall carry byte_out and last;
// last marks the final byte caused by one input item. Items that cause no
// byte produce no output transfer.
// Config: cfg_valid / cfg_ready write cfg_data to register cfg_index
// (0 interpret_escapes, 1 append_newline); cfg_ready is always high. Writes
// must be made only while the block is idle; the block does not enforce this.
// Path: an item is held in the input register, decoded in one pass into
// a three-byte output buffer, and its first byte is driven from that buffer.
// Throughput is one item per cycle while each item gives at most one byte
// and the output is not stalled; an item giving two or three bytes holds
// the input while the single-byte output port drains the buffer.
// A stall on the output holds the buffer, which in turn stalls the input.
// Reset (rst, synchronous) empties both registers, clears the escape state
// and sets interpret_escapes to 0 and append_newline to 1.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_top
  import bed_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        has_char,
  input  wire [7:0]  char_in,
  input  wire        end_of_arg,
  input  wire        end_of_all,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] byte_out,
  output logic       last,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_index,
  input  wire        cfg_data
);

  logic            interpret_escapes;
  logic            append_newline;
  phase_t          phase;
  logic [7:0]      acc;
  logic            in_reg_valid;
  item_t           in_reg;
  logic [2:0][7:0] obuf;
  logic [1:0]      rem;
  result_t         res;
  logic            in_fire;
  logic            out_fire;
  logic            decode_fire;
  logic            obuf_free;

  assign cfg_ready   = 1'b1;
  assign out_valid   = (rem != 2'd0);
  assign byte_out    = obuf[0];
  assign last        = (rem == 2'd1);
  assign out_fire    = out_valid & ~out_stall;
  assign obuf_free   = (rem == 2'd0) | ((rem == 2'd1) & ~out_stall);
  assign decode_fire = in_reg_valid & obuf_free;
  assign in_stall    = in_reg_valid & ~obuf_free;
  assign in_fire     = in_valid & ~in_stall;

  bed_decode u_decode (
    .item              (in_reg),
    .phase             (phase),
    .acc               (acc),
    .interpret_escapes (interpret_escapes),
    .append_newline    (append_newline),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interpret_escapes <= 1'b0;
      append_newline    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INTERPRET: interpret_escapes <= cfg_data;
        CFG_NEWLINE:   append_newline    <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_fire) begin
      in_reg_valid <= 1'b1;
    end else if (decode_fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_reg.has_char   <= has_char;
      in_reg.char_in    <= char_in;
      in_reg.end_of_arg <= end_of_arg;
      in_reg.end_of_all <= end_of_all;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      acc   <= 8'd0;
    end else if (decode_fire) begin
      phase <= res.phase_next;
      acc   <= res.acc_next;
    end
  end

  // output buffer: load a whole item, then shift one byte per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (decode_fire) begin
      rem <= res.count;
    end else if (out_fire) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (decode_fire) begin
      obuf <= res.bytes;
    end else if (out_fire) begin
      obuf <= {8'h00, obuf[2:1]};
    end
  end

`ifndef SYNTHESIS
  a_arg_end_clears: assert property (@(posedge clk) disable iff (rst)
    decode_fire && (in_reg.end_of_arg || in_reg.end_of_all)
      |=> phase == PH_NORMAL && acc == 8'd0)
    else $error("escape state survived an argument end");

  a_plain_holds_phase: assert property (@(posedge clk) disable iff (rst)
    decode_fire && !interpret_escapes && !in_reg.end_of_arg && !in_reg.end_of_all
      |=> $stable(phase) && $stable(acc))
    else $error("plain mode advanced the escape state");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    out_fire && !last |=> out_valid)
    else $error("byte sequence cut short before last");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    out_fire && last && !decode_fire |=> !out_valid)
    else $error("output still valid after last byte");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_reg_valid)
    else $error("accepted item lost from input register");
`endif

endmodule
`default_nettype wire
